FILE: src/vmpi_pkg.sv
package vmpi_pkg;

  localparam int MAP_ENTRIES      = 256;
  localparam int POINTS_PER_VOXEL = 20;
  localparam int COORD_BITS       = 24;

  // configuration register widths
  localparam int VS_W   = 16;
  localparam int SPC_W  = 16;
  localparam int MAXP_W = 5;
  localparam int MINP_W = 5;
  localparam int PD_W   = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int KEY_W   = 16;
  localparam int ENT_W   = $clog2(MAP_ENTRIES);
  localparam int CNT_W   = ENT_W + 1;
  localparam int PT_W    = $clog2(POINTS_PER_VOXEL + 1);
  localparam int PADDR_W = $clog2(MAP_ENTRIES * POINTS_PER_VOXEL);
  localparam int DCNT_W  = $clog2(COORD_BITS + 1);
  localparam int SQ_IN_W = (COORD_BITS > PD_W) ? COORD_BITS : PD_W;
  localparam int SQ_W    = 2 * SQ_IN_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int BEST_W  = 2 * VS_W + 4;
  localparam int RM_W    = 9;
  localparam int ST_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRUNE_DIST = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [ST_W-1:0] ST_NEW        = 3'd1;
  localparam logic [ST_W-1:0] ST_CLOSE      = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd3;
  localparam logic [ST_W-1:0] ST_FEW        = 3'd4;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd5;
  localparam logic [ST_W-1:0] ST_PRUNED     = 3'd6;

  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [RM_W-1:0] removed_count;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } pt_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] x;
    logic signed [KEY_W-1:0] y;
    logic signed [KEY_W-1:0] z;
  } key_t;

  typedef struct packed {
    logic [PT_W-1:0] fill;
    key_t            key;
  } kword_t;

endpackage

FILE: src/voxel_map_point_insert.sv
// Voxel map point insert: one command at a time, busy high while it works.
// Insert: key division per axis, squares of the thresholds, a table scan, an
// evaluate step, then a read and distance per stored point of the hit voxel
// (up to 19) and a decision. Prune: a scan with a read and distance per live voxel.
// Result strobe rises in the same cycle that busy falls, lasts one cycle and cannot be stalled. Reset
// clears the voxel table at once (valid flags) and loads the register defaults.
module voxel_map_point_insert import vmpi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  in_t                   in_i,
  output logic                  busy,
  output logic                  res_valid_o,
  output out_t                  res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV_GO = 4'd1;
  localparam logic [3:0] S_DIV_WT = 4'd2;
  localparam logic [3:0] S_THR    = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_PT_RD  = 4'd6;
  localparam logic [3:0] S_SQ     = 4'd7;
  localparam logic [3:0] S_DEC    = 4'd8;
  localparam logic [3:0] S_PSCAN  = 4'd9;

  function automatic logic [PADDR_W-1:0] pt_base(input logic [ENT_W-1:0] e);
    return PADDR_W'(e) * PADDR_W'(POINTS_PER_VOXEL);
  endfunction

  // configuration registers
  logic [VS_W-1:0]   vs_q;
  logic [SPC_W-1:0]  spc_q;
  logic [MAXP_W-1:0] maxp_q;
  logic [MINP_W-1:0] minp_q;
  logic [PD_W-1:0]   pd_q;

  logic [3:0] state_q, state_d;

  // item context
  logic                  kind_q;
  pt_t                   pos_q;
  key_t                  key_q;
  logic [1:0]            axis_q;
  logic [1:0]            sub_q;
  logic [CNT_W-1:0]      idx_q;
  logic                  rd_pend_q;
  logic [ENT_W-1:0]      rd_idx_q;
  logic                  hit_found_q;
  logic [ENT_W-1:0]      hit_q;
  logic                  free_found_q;
  logic [ENT_W-1:0]      free_q;
  logic [PT_W-1:0]       fill_q;
  logic [PT_W-1:0]       j_q;
  logic [BEST_W-1:0]     best_q;
  logic [2*SPC_W-1:0]    spc2_q;
  logic [2*PD_W-1:0]     lim_q;
  logic [DIST_W-1:0]     acc_q;
  logic [SQ_W-1:0]       prod_q;
  logic [RM_W-1:0]       removed_q;
  logic [MAP_ENTRIES-1:0] valid_q;

  logic       res_valid_q;
  out_t       res_q;

  // voxel table: key plus fill per entry; point store per entry and slot
  kword_t kmem [MAP_ENTRIES];
  pt_t    pmem [MAP_ENTRIES*POINTS_PER_VOXEL];
  kword_t kmem_rd_q;
  pt_t    pmem_rd_q;

  logic               kmem_we;
  logic               pmem_we;
  logic               pmem_re;
  logic [ENT_W-1:0]   wr_ent;
  logic [PT_W-1:0]    wr_j;
  logic [PADDR_W-1:0] pmem_waddr;
  logic [PADDR_W-1:0] pmem_raddr;
  logic [ENT_W-1:0]   rd_ent;
  kword_t             kmem_wdata;

  // shared divider
  logic                  div_start;
  logic                  div_done;
  logic signed [KEY_W-1:0] div_quot;
  logic signed [COORD_BITS-1:0] div_dvd;

  // shared squarer
  logic [SQ_IN_W-1:0]    sq_a;
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS-1:0] diff_mag;
  logic [DIST_W-1:0]     sq_sum;

  logic [VS_W-1:0] vs_eff;
  logic [PT_W-1:0] cap;
  logic            key_match;
  logic            res_fire;
  logic [ST_W-1:0] res_status;

  assign vs_eff = (vs_q == '0) ? VS_W'(1) : vs_q;

  always_comb begin
    if (maxp_q == '0) begin
      cap = PT_W'(1);
    end else if (int'(maxp_q) > POINTS_PER_VOXEL) begin
      cap = PT_W'(POINTS_PER_VOXEL);
    end else begin
      cap = PT_W'(maxp_q);
    end
  end

  assign key_match = (kmem_rd_q.key == key_q);

  always_comb begin
    case (axis_q)
      2'd0:    div_dvd = pos_q.x;
      2'd1:    div_dvd = pos_q.y;
      default: div_dvd = pos_q.z;
    endcase
  end

  vmpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (vs_eff),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // per-axis difference between stored point and the item position
  always_comb begin
    case (sub_q)
      2'd0:    diff = {pmem_rd_q.x[COORD_BITS-1], pmem_rd_q.x} - {pos_q.x[COORD_BITS-1], pos_q.x};
      2'd1:    diff = {pmem_rd_q.y[COORD_BITS-1], pmem_rd_q.y} - {pos_q.y[COORD_BITS-1], pos_q.y};
      default: diff = {pmem_rd_q.z[COORD_BITS-1], pmem_rd_q.z} - {pos_q.z[COORD_BITS-1], pos_q.z};
    endcase
  end

  always_comb begin
    logic [COORD_BITS:0] m;
    m = diff[COORD_BITS] ? -diff : diff;
    diff_mag = m[COORD_BITS-1:0];
  end

  always_comb begin
    if (state_q == S_THR) begin
      if (kind_q) begin
        sq_a = SQ_IN_W'(pd_q);
      end else if (sub_q == 2'd0) begin
        sq_a = SQ_IN_W'(vs_eff);
      end else begin
        sq_a = SQ_IN_W'(spc_q);
      end
    end else begin
      sq_a = SQ_IN_W'(diff_mag);
    end
  end

  assign sq_sum = acc_q + DIST_W'(prod_q);

  // table addressing
  assign rd_ent     = kind_q ? idx_q[ENT_W-1:0] : hit_q;
  assign pmem_raddr = pt_base(rd_ent) + PADDR_W'(j_q);
  assign wr_ent     = hit_found_q ? hit_q : free_q;
  assign wr_j       = hit_found_q ? fill_q : '0;
  assign pmem_waddr = pt_base(wr_ent) + PADDR_W'(wr_j);
  assign kmem_wdata = '{fill: wr_j + PT_W'(1), key: key_q};

  // sequencer
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    kmem_we    = 1'b0;
    pmem_we    = 1'b0;
    pmem_re    = 1'b0;
    res_fire   = 1'b0;
    res_status = ST_ADDED;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = in_i.kind ? S_THR : S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (div_done) begin
          state_d = (axis_q == 2'd2) ? S_THR : S_DIV_GO;
        end
      end
      S_THR: begin
        if (kind_q && sub_q == 2'd1) begin
          state_d = S_PSCAN;
        end else if (!kind_q && sub_q == 2'd2) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == CNT_W'(MAP_ENTRIES) && !rd_pend_q) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (hit_found_q) begin
          if (fill_q >= cap) begin
            res_fire   = 1'b1;
            res_status = ST_FULL;
            state_d    = S_IDLE;
          end else if (fill_q == '0) begin
            state_d = S_DEC;
          end else begin
            state_d = S_PT_RD;
          end
        end else begin
          res_fire = 1'b1;
          state_d  = S_IDLE;
          if (minp_q != '0) begin
            res_status = ST_FEW;
          end else if (!free_found_q) begin
            res_status = ST_TABLE_FULL;
          end else begin
            kmem_we    = 1'b1;
            pmem_we    = 1'b1;
            res_status = ST_NEW;
          end
        end
      end
      S_PT_RD: begin
        pmem_re = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        if (sub_q == 2'd3) begin
          if (kind_q) begin
            state_d = S_PSCAN;
          end else if ((j_q + PT_W'(1)) == fill_q) begin
            state_d = S_DEC;
          end else begin
            state_d = S_PT_RD;
          end
        end
      end
      S_DEC: begin
        res_fire = 1'b1;
        state_d  = S_IDLE;
        if (!(DIST_W'(best_q) > DIST_W'(spc2_q))) begin
          res_status = ST_CLOSE;
        end else if (minp_q != '0 && int'(fill_q) < int'(minp_q)) begin
          res_status = ST_FEW;
        end else begin
          kmem_we    = 1'b1;
          pmem_we    = 1'b1;
          res_status = ST_ADDED;
        end
      end
      S_PSCAN: begin
        if (idx_q == CNT_W'(MAP_ENTRIES)) begin
          res_fire   = 1'b1;
          res_status = ST_PRUNED;
          state_d    = S_IDLE;
        end else if (valid_q[idx_q[ENT_W-1:0]]) begin
          state_d = S_PT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vs_q         <= VS_W'(205);
      spc_q        <= SPC_W'(26);
      maxp_q       <= MAXP_W'(20);
      minp_q       <= '0;
      pd_q         <= PD_W'(51200);
      kind_q       <= 1'b0;
      pos_q        <= '0;
      key_q        <= '0;
      axis_q       <= '0;
      sub_q        <= '0;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_idx_q     <= '0;
      hit_found_q  <= 1'b0;
      hit_q        <= '0;
      free_found_q <= 1'b0;
      free_q       <= '0;
      fill_q       <= '0;
      j_q          <= '0;
      best_q       <= '0;
      spc2_q       <= '0;
      lim_q        <= '0;
      acc_q        <= '0;
      prod_q       <= '0;
      removed_q    <= '0;
      valid_q      <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q     <= state_d;
      prod_q      <= SQ_W'(sq_a) * SQ_W'(sq_a);
      res_valid_q <= res_fire;
      if (res_fire) begin
        res_q.status        <= res_status;
        res_q.removed_count <= kind_q ? removed_q : '0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VOXEL_SIZE: vs_q   <= cfg_data_i[VS_W-1:0];
          CFG_MIN_SPACE:  spc_q  <= cfg_data_i[SPC_W-1:0];
          CFG_MAX_POINTS: maxp_q <= cfg_data_i[MAXP_W-1:0];
          CFG_MIN_POINTS: minp_q <= cfg_data_i[MINP_W-1:0];
          CFG_PRUNE_DIST: pd_q   <= cfg_data_i[PD_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            kind_q       <= in_i.kind;
            pos_q        <= '{x: in_i.pos_x, y: in_i.pos_y, z: in_i.pos_z};
            axis_q       <= '0;
            sub_q        <= '0;
            idx_q        <= '0;
            rd_pend_q    <= 1'b0;
            hit_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            j_q          <= '0;
            removed_q    <= '0;
          end
        end
        S_DIV_WT: begin
          if (div_done) begin
            case (axis_q)
              2'd0:    key_q.x <= div_quot;
              2'd1:    key_q.y <= div_quot;
              default: key_q.z <= div_quot;
            endcase
            axis_q <= axis_q + 2'd1;
          end
        end
        S_THR: begin
          sub_q <= sub_q + 2'd1;
          if (sub_q == 2'd1) begin
            if (kind_q) begin
              lim_q <= prod_q[2*PD_W-1:0];
              sub_q <= '0;
            end else begin
              // ten times the squared voxel size
              best_q <= (BEST_W'(prod_q[2*VS_W-1:0]) << 3) +
                        (BEST_W'(prod_q[2*VS_W-1:0]) << 1);
            end
          end
          if (sub_q == 2'd2) begin
            spc2_q <= prod_q[2*SPC_W-1:0];
            sub_q  <= '0;
          end
        end
        S_SCAN: begin
          // issue one key read a cycle, check it the cycle after
          rd_pend_q <= (idx_q != CNT_W'(MAP_ENTRIES));
          rd_idx_q  <= idx_q[ENT_W-1:0];
          if (idx_q != CNT_W'(MAP_ENTRIES)) begin
            idx_q <= idx_q + CNT_W'(1);
          end
          if (rd_pend_q) begin
            if (valid_q[rd_idx_q]) begin
              if (!hit_found_q && key_match) begin
                hit_found_q <= 1'b1;
                hit_q       <= rd_idx_q;
                fill_q      <= kmem_rd_q.fill;
              end
            end else if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_q       <= rd_idx_q;
            end
          end
        end
        S_EVAL: begin
          j_q   <= '0;
          sub_q <= '0;
          if (!hit_found_q && minp_q == '0 && free_found_q) begin
            valid_q[free_q] <= 1'b1;
          end
        end
        S_SQ: begin
          sub_q <= sub_q + 2'd1;
          case (sub_q)
            2'd1: acc_q <= DIST_W'(prod_q);
            2'd2: acc_q <= acc_q + DIST_W'(prod_q);
            2'd3: begin
              if (kind_q) begin
                // drop voxels whose first point is out of range
                if (sq_sum > DIST_W'(lim_q)) begin
                  valid_q[idx_q[ENT_W-1:0]] <= 1'b0;
                  removed_q <= removed_q + RM_W'(1);
                end
                idx_q <= idx_q + CNT_W'(1);
              end else begin
                if (sq_sum < DIST_W'(best_q)) begin
                  best_q <= sq_sum[BEST_W-1:0];
                end
                j_q <= j_q + PT_W'(1);
              end
            end
            default: ;
          endcase
        end
        S_PSCAN: begin
          if (idx_q != CNT_W'(MAP_ENTRIES) && !valid_q[idx_q[ENT_W-1:0]]) begin
            idx_q <= idx_q + CNT_W'(1);
          end
          sub_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // key and fill memory
  always_ff @(posedge clk_i) begin
    if (kmem_we) begin
      kmem[wr_ent] <= kmem_wdata;
    end
    kmem_rd_q <= kmem[idx_q[ENT_W-1:0]];
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (pmem_we) begin
      pmem[pmem_waddr] <= pos_q;
    end
    if (pmem_re) begin
      pmem_rd_q <= pmem[pmem_raddr];
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: src/vmpi_div.sv
// Restoring divider, one quotient bit a cycle; truncates toward zero and
// saturates the quotient to a signed key.
module vmpi_div import vmpi_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] dvd_i,
  input  logic        [VS_W-1:0]       dvs_i,
  output logic                         done_o,
  output logic signed [KEY_W-1:0]      quot_o
);

  logic                  busy_q;
  logic                  done_q;
  logic                  neg_q;
  logic [DCNT_W-1:0]     cnt_q;
  logic [COORD_BITS-1:0] q_q;
  logic [VS_W-1:0]       rem_q;
  logic [VS_W-1:0]       dvs_q;
  logic [VS_W:0]         rem_sh;
  logic [VS_W:0]         rem_sub;
  logic                  ge;

  assign rem_sh  = {rem_q, q_q[COORD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      q_q    <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DCNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(COORD_BITS);
        neg_q  <= dvd_i[COORD_BITS-1];
        q_q    <= dvd_i[COORD_BITS-1] ? -dvd_i : dvd_i;
        rem_q  <= '0;
        dvs_q  <= dvs_i;
      end else if (busy_q) begin
        q_q   <= {q_q[COORD_BITS-2:0], ge};
        rem_q <= ge ? rem_sub[VS_W-1:0] : rem_sh[VS_W-1:0];
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // saturate magnitude to the signed key range
  always_comb begin
    if (neg_q) begin
      if (q_q > COORD_BITS'(32768)) begin
        quot_o = -KEY_W'(32768);
      end else begin
        quot_o = -q_q[KEY_W-1:0];
      end
    end else begin
      if (q_q > COORD_BITS'(32767)) begin
        quot_o = KEY_W'(32767);
      end else begin
        quot_o = q_q[KEY_W-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

FILE: src/vmpi_chk.sv
module vmpi_chk import vmpi_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o,
  input out_t res_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted command");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a command in progress");

  a_count_only_prune: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_PRUNED) |-> (res_o.removed_count == '0))
    else $error("removed count on an insert result");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status != 3'd7))
    else $error("undefined status code");

endmodule

bind voxel_map_point_insert vmpi_chk u_vmpi_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
